FILE: rtl/brl_pkg.sv
// Shared types, codes and constants of the boundary range lookup block.
package brl_pkg;

  // Default table depth
  localparam int unsigned MAX_POINTS_DEF = 64;

  // Port widths
  localparam int unsigned IN_W    = 168;
  localparam int unsigned OUT_W   = 72;
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned CFG_DW  = 31;
  localparam int unsigned ENTRY_W = 96;

  // Register reset values
  localparam logic [2:0]  KIND_RST  = 3'd5;
  localparam logic [30:0] LIMIT_RST = 31'd13107200;
  localparam logic [15:0] TOL_RST   = 16'd1;

  // Boundary kinds that matter to the unblocked query
  localparam logic [2:0] KIND_FOLLOW   = 3'd2;
  localparam logic [2:0] KIND_OVERTAKE = 3'd3;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RANGE = 2'd1,
    CMD_UNBLK = 2'd2,
    CMD_CONT  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_OUTSIDE = 3'd1,
    STS_REJECT  = 3'd2,
    STS_UNSUP   = 3'd3,
    STS_FULL    = 3'd4,
    STS_FEW     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    CFG_KIND  = 2'd0,
    CFG_LIMIT = 2'd1,
    CFG_TOL   = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    FSM_IDLE, FSM_CHECK, FSM_SRCH, FSM_SRCH_CMP, FSM_RD_L, FSM_RD_R, FSM_CAP_R,
    FSM_PREP, FSM_DIV, FSM_MUL_A, FSM_MUL_B, FSM_MUL_C, FSM_MUL_D, FSM_RESULT,
    FSM_FINISH
  } fsm_e;

  typedef enum logic [1:0] {RD_MID, RD_L, RD_R} rd_sel_e;

  typedef enum logic [1:0] {MUL_A, MUL_B, MUL_C, MUL_D} mul_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     accept;
    logic     check;
    logic     srch_upd;
    rd_sel_e  rd_sel;
    logic     cap_l;
    logic     cap_r;
    logic     prep;
    logic     div_step;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     result;
    logic     out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic early;
    logic is_cont;
    logic srch_busy;
    logic div_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: rtl/brl_ram.sv
// Generic single-port-write, registered-read RAM.
module brl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/brl_ctrl.sv
// Controller state machine: sequences check, search, divide, multiply and output.
module brl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brl_pkg::dp_stat_t stat_i,
  output brl_pkg::ctrl_cmd_t cmd_o
);
  import brl_pkg::*;

  fsm_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.rd_sel  = RD_MID;
    cmd_o.mul_sel = MUL_A;
    in_ready_o = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = FSM_CHECK;
        end
      end
      FSM_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = stat_i.early ? FSM_FINISH : FSM_SRCH;
      end
      FSM_SRCH: begin
        state_d = stat_i.srch_busy ? FSM_SRCH_CMP : FSM_RD_L;
      end
      FSM_SRCH_CMP: begin
        cmd_o.srch_upd = 1'b1;
        state_d        = FSM_SRCH;
      end
      FSM_RD_L: begin
        cmd_o.rd_sel = RD_L;
        state_d      = FSM_RD_R;
      end
      FSM_RD_R: begin
        cmd_o.rd_sel = RD_R;
        cmd_o.cap_l  = 1'b1;
        state_d      = FSM_CAP_R;
      end
      FSM_CAP_R: begin
        cmd_o.cap_r = 1'b1;
        state_d     = FSM_PREP;
      end
      FSM_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = stat_i.is_cont ? FSM_MUL_A : FSM_DIV;
      end
      FSM_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = FSM_MUL_A;
        end
      end
      FSM_MUL_A: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_A;
        state_d       = FSM_MUL_B;
      end
      FSM_MUL_B: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_B;
        state_d       = stat_i.is_cont ? FSM_MUL_C : FSM_RESULT;
      end
      FSM_MUL_C: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_C;
        state_d       = FSM_MUL_D;
      end
      FSM_MUL_D: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MUL_D;
        state_d       = FSM_RESULT;
      end
      FSM_RESULT: begin
        cmd_o.result = 1'b1;
        state_d      = FSM_FINISH;
      end
      FSM_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

endmodule

FILE: rtl/brl_dp.sv
// Datapath: table store, search pointers, serial divider, shared multiplier, output word.
module brl_dp #(
  parameter int unsigned MAX_POINTS = brl_pkg::MAX_POINTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [brl_pkg::IN_W-1:0]   in_data_i,
  input  logic                       cfg_we_i,
  input  logic [brl_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [brl_pkg::CFG_DW-1:0] cfg_data_i,
  input  brl_pkg::ctrl_cmd_t         cmd_i,
  output brl_pkg::dp_stat_t          stat_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [brl_pkg::OUT_W-1:0]  out_data_o
);
  import brl_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  // Configuration registers
  logic [2:0]  kind_q;
  logic [30:0] limit_q;
  logic [15:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_RST;
      limit_q <= LIMIT_RST;
      tol_q   <= TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_KIND:  kind_q  <= cfg_data_i[2:0];
        CFG_LIMIT: limit_q <= cfg_data_i;
        CFG_TOL:   tol_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Captured input word
  cmd_e               cmd_q;
  logic               new_q;
  logic signed [31:0] pt_q, pl_q, pu_q, qt_q, qd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q <= cmd_e'(in_data_i[1:0]);
      new_q <= in_data_i[2];
      pt_q  <= in_data_i[34:3];
      pl_q  <= in_data_i[66:35];
      pu_q  <= in_data_i[98:67];
      qt_q  <= in_data_i[130:99];
      qd_q  <= in_data_i[162:131];
    end
  end

  // Fill count and span ends
  logic [CW-1:0]      cnt_q, cnt_d, eff_cnt;
  logic signed [31:0] first_q, last_q;
  logic               rej, full, wr;

  assign eff_cnt = new_q ? '0 : cnt_q;
  assign rej     = (pu_q < pl_q) || ((eff_cnt != '0) && (pt_q <= last_q));
  assign full    = eff_cnt >= CW'(MAX_POINTS);
  assign wr      = cmd_i.check && (cmd_q == CMD_LOAD) && !rej && !full;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.check && (cmd_q == CMD_LOAD)) begin
      cnt_d = wr ? eff_cnt + CW'(1) : eff_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      last_q <= pt_q;
      if (eff_cnt == '0) begin
        first_q <= pt_q;
      end
    end
  end

  // Table memory: {upper, lower, time}
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  logic signed [31:0] rd_time;

  brl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr),
    .waddr_i(eff_cnt[AW-1:0]),
    .wdata_i({pu_q, pl_q, pt_q}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_time = rdata[31:0];

  // Early decisions
  logic signed [33:0] qt34, tmin34, tmax34, win_lo, win_hi, lim34;
  logic               few, in_win;
  logic               early;
  status_e            e_sts;
  logic [31:0]        e_ru;

  assign qt34   = 34'(qt_q);
  assign tmin34 = 34'(first_q);
  assign tmax34 = 34'(last_q);
  assign win_lo = tmin34 - $signed({18'b0, tol_q});
  assign win_hi = tmax34 + $signed({18'b0, tol_q});
  assign lim34  = $signed({3'b0, limit_q});
  assign few    = cnt_q < CW'(2);
  assign in_win = (qt34 >= win_lo) && (qt34 <= win_hi);

  always_comb begin
    early = 1'b0;
    e_sts = STS_OK;
    e_ru  = '0;
    if (cmd_q == CMD_LOAD) begin
      early = 1'b1;
      e_sts = rej ? STS_REJECT : (full ? STS_FULL : STS_OK);
    end else if (few) begin
      early = 1'b1;
      e_sts = STS_FEW;
    end else begin
      case (cmd_q)
        CMD_RANGE: begin
          if (qt_q < first_q || qt_q > last_q) begin
            early = 1'b1;
            e_sts = STS_OUTSIDE;
          end
        end
        CMD_UNBLK: begin
          e_ru = {1'b0, limit_q};
          if (!in_win) begin
            early = 1'b1;
          end else if (kind_q > KIND_OVERTAKE) begin
            early = 1'b1;
            e_sts = STS_UNSUP;
          end
        end
        CMD_CONT: begin
          if (qt_q <= first_q || qt_q >= last_q) begin
            early = 1'b1;
            e_sts = STS_OUTSIDE;
          end
        end
        default: ;
      endcase
    end
  end

  // Binary search for the first entry not below the query time
  logic [CW-1:0] lo_q, hi_q, mid, l_idx, r_idx;
  logic [CW:0]   mid_sum;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[CW:1];

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      lo_q <= '0;
      hi_q <= cnt_q;
    end else if (cmd_i.srch_upd) begin
      if (rd_time < qt_q) begin
        lo_q <= mid + CW'(1);
      end else begin
        hi_q <= mid;
      end
    end
  end

  // Bracket from the search result
  always_comb begin
    if (lo_q == '0) begin
      l_idx = '0;
      r_idx = '0;
    end else if (lo_q >= cnt_q) begin
      l_idx = cnt_q - CW'(1);
      r_idx = cnt_q - CW'(1);
    end else begin
      l_idx = lo_q - CW'(1);
      r_idx = lo_q;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_L:    raddr = l_idx[AW-1:0];
      RD_R:    raddr = r_idx[AW-1:0];
      default: raddr = mid[AW-1:0];
    endcase
  end

  // Bracket entries
  logic signed [31:0] tl_q, ll_q, ul_q, tr_q, lr_q, ur_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_l) begin
      tl_q <= rdata[31:0];
      ll_q <= rdata[63:32];
      ul_q <= rdata[95:64];
    end
    if (cmd_i.cap_r) begin
      tr_q <= rdata[31:0];
      lr_q <= rdata[63:32];
      ur_q <= rdata[95:64];
    end
  end

  // Operand preparation and serial divider
  logic signed [33:0] num, den;
  logic signed [33:0] dsu_q, dsl_q, dtl_q, dtr_q, bur_q, bul_q, blr_q, bll_q;
  logic [33:0]        rem_q, den_q, rem_sub;
  logic [16:0]        quo_q, quo_eff;
  logic [4:0]         dcnt_q;
  logic               triv_q, ge;

  assign num     = qt34 - 34'(tl_q);
  assign den     = 34'(tr_q) - 34'(tl_q);
  assign ge      = rem_q >= den_q;
  assign rem_sub = ge ? rem_q - den_q : rem_q;
  assign quo_eff = triv_q ? '0 : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      triv_q <= (den <= 0) || (num < 0);
      rem_q  <= num;
      den_q  <= den;
      quo_q  <= '0;
      dcnt_q <= '0;
      dsu_q  <= 34'(ur_q) - 34'(ul_q);
      dsl_q  <= 34'(lr_q) - 34'(ll_q);
      dtl_q  <= 34'(tl_q) - qt34;
      dtr_q  <= 34'(tr_q) - qt34;
      bur_q  <= 34'(ur_q) - 34'(qd_q);
      bul_q  <= 34'(ul_q) - 34'(qd_q);
      blr_q  <= 34'(lr_q) - 34'(qd_q);
      bll_q  <= 34'(ll_q) - 34'(qd_q);
    end else if (cmd_i.div_step) begin
      rem_q  <= {rem_sub[32:0], 1'b0};
      quo_q  <= {quo_q[15:0], ge};
      dcnt_q <= dcnt_q + 5'd1;
    end
  end

  // Shared multiplier, one product per cycle
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [67:0] pa_q, pb_q, pc_q, pd_q;

  always_comb begin
    ma = dsu_q;
    mb = $signed({17'b0, quo_eff});
    if (cmd_q == CMD_CONT) begin
      case (cmd_i.mul_sel)
        MUL_A:   begin ma = dtl_q; mb = bur_q; end
        MUL_B:   begin ma = bul_q; mb = dtr_q; end
        MUL_C:   begin ma = dtl_q; mb = blr_q; end
        default: begin ma = bll_q; mb = dtr_q; end
      endcase
    end else if (cmd_i.mul_sel == MUL_B) begin
      ma = dsl_q;
    end
  end

  assign prod = ma * mb;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      case (cmd_i.mul_sel)
        MUL_A:   pa_q <= prod;
        MUL_B:   pb_q <= prod;
        MUL_C:   pc_q <= prod;
        default: pd_q <= prod;
      endcase
    end
  end

  // Final values from products
  logic signed [33:0] iu, il;
  logic signed [68:0] du, dl;
  logic               su_pos, su_neg, sl_pos, sl_neg;
  logic [31:0]        f_ru, f_rl;
  logic               f_in;

  assign iu     = 34'(ul_q) + pa_q[49:16];
  assign il     = 34'(ll_q) + pb_q[49:16];
  assign du     = 69'(pa_q) - 69'(pb_q);
  assign dl     = 69'(pc_q) - 69'(pd_q);
  assign su_neg = du[68];
  assign su_pos = !du[68] && (du != '0);
  assign sl_neg = dl[68];
  assign sl_pos = !dl[68] && (dl != '0);

  always_comb begin
    f_ru = '0;
    f_rl = '0;
    f_in = 1'b0;
    case (cmd_q)
      CMD_RANGE: begin
        f_ru = (iu > lim34) ? {1'b0, limit_q} : iu[31:0];
        f_rl = (il < 0) ? '0 : il[31:0];
      end
      CMD_UNBLK: begin
        if (kind_q <= KIND_FOLLOW) begin
          f_ru = il[31:0];
        end else begin
          f_ru = {1'b0, limit_q};
          f_rl = (iu > 0) ? iu[31:0] : '0;
        end
      end
      CMD_CONT: f_in = (su_pos && sl_neg) || (su_neg && sl_pos);
      default: ;
    endcase
  end

  // Result holding registers
  logic [2:0]  rs_q;
  logic [31:0] rru_q, rrl_q;
  logic        rin_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      rs_q  <= e_sts;
      rru_q <= e_ru;
      rrl_q <= '0;
      rin_q <= 1'b0;
    end else if (cmd_i.result) begin
      rs_q  <= STS_OK;
      rru_q <= f_ru;
      rrl_q <= f_rl;
      rin_q <= f_in;
    end
  end

  // Output register
  logic             ovalid_q;
  logic [OUT_W-1:0] odata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      odata_q <= {4'b0, rin_q, rrl_q, rru_q, rs_q};
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  assign stat_o.early     = early;
  assign stat_o.is_cont   = cmd_q == CMD_CONT;
  assign stat_o.srch_busy = lo_q < hi_q;
  assign stat_o.div_last  = dcnt_q == 5'd16;
  assign stat_o.out_free  = !ovalid_q || out_ready_i;

endmodule

FILE: rtl/st_boundary_range_lookup.sv
// Top level of the boundary range lookup: controller, datapath and port wiring.
//
// Input stream s_axis_*: one word per command (load pair, range query,
// unblocked range query, containment test). Output stream m_axis_*: exactly
// one result word per command. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle.
// One item is handled at a time. A load or any query answered without a
// search (too few entries, outside span, defaults) goes from the check step
// straight to the finish step. Searched queries pass a check step, binary
// search steps (at most floor(log2(entries))+1 over the single table read
// port), the bracket reads and set-up, the bit-serial divider (range and
// unblocked queries), two or four products on the shared multiplier and the
// result and finish steps.
// tready is high only while no item is in work; the result sits in an
// output register, so a stalled receiver holds the result and the block
// waits in its final step until the register frees.
// Reset empties the table (fill count zero) and sets the registers to
// kind unknown, limit 200 m and tolerance of one LSB; the table memory
// itself is not cleared.
module st_boundary_range_lookup #(
  parameter int unsigned MAX_POINTS = brl_pkg::MAX_POINTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // cmd, start_new, pair_time, pair_lower, pair_upper, query_time,
  // query_distance (from bit 0 up)
  input  logic [brl_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // status, range_upper, range_lower, inside_res (from bit 0 up)
  output logic [brl_pkg::OUT_W-1:0]  m_axis_tdata,
  input  logic                       cfg_we_i,
  input  logic [brl_pkg::CFG_AW-1:0] cfg_idx_i,
  input  logic [brl_pkg::CFG_DW-1:0] cfg_data_i
);
  import brl_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  brl_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  brl_dp #(
    .MAX_POINTS(MAX_POINTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata)
  );

endmodule

FILE: rtl/brl_chk.sv
// Port-level checker for the boundary range lookup, bound to the top level.
module brl_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [brl_pkg::OUT_W-1:0] m_axis_tdata
);
  import brl_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result word changed");

  // One word in work at a time: no acceptance right after one
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("word accepted while another in work");

  // Status code within its defined set
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= STS_FEW)
    else $error("undefined status code");

  // Containment hit carries ok status and zero ranges
  a_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[67] |->
      m_axis_tdata[2:0] == STS_OK && m_axis_tdata[66:3] == '0)
    else $error("inside flag with non-zero ranges or bad status");

endmodule

bind st_boundary_range_lookup brl_chk u_brl_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench of the boundary range lookup block: directed and random words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import brl_pkg::*;

  localparam int TBL_DEPTH  = 64;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    cmd_e               cmd;
    logic               start_new;
    logic signed [31:0] pair_time;
    logic signed [31:0] pair_lower;
    logic signed [31:0] pair_upper;
    logic signed [31:0] query_time;
    logic signed [31:0] query_dist;
  } cmd_word_t;

  typedef struct {
    status_e     status;
    logic [31:0] range_upper;
    logic [31:0] range_lower;
    logic        in_res;
  } result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // cmd, start_new, pair_time, pair_lower, pair_upper, query_time,
  // query_distance (from bit 0 up)
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // status, range_upper, range_lower, inside_res (from bit 0 up)
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_we_i = 1'b0;
  logic [CFG_AW-1:0] cfg_idx_i = '0;
  logic [CFG_DW-1:0] cfg_data_i = '0;

  // Bounds table as the block should hold it
  logic signed [31:0] bnd_time[TBL_DEPTH];
  logic signed [31:0] bnd_lower[TBL_DEPTH];
  logic signed [31:0] bnd_upper[TBL_DEPTH];
  int                 bnd_count = 0;
  logic [2:0]         kind_reg = KIND_RST;
  longint             limit_reg = longint'(LIMIT_RST);
  longint             tol_reg = longint'(TOL_RST);

  result_t pending_results[$];
  int      err_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      quiet_cycles = 0;

  st_boundary_range_lookup dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // First entry not below t, turned into a bracketing pair
  function automatic void find_bracket(longint t, output int l, output int r);
    int lo, hi, mid;
    lo = 0;
    hi = bnd_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (longint'(bnd_time[mid]) < t) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) begin
      l = 0; r = 0;
    end else if (lo >= bnd_count) begin
      l = bnd_count - 1; r = bnd_count - 1;
    end else begin
      l = lo - 1; r = lo;
    end
  endfunction

  function automatic longint interp_bound(bit use_upper, int l, int r, longint t);
    longint sl, sr, num, den, ds, p;
    longint unsigned ratio;
    sl = use_upper ? longint'(bnd_upper[l]) : longint'(bnd_lower[l]);
    sr = use_upper ? longint'(bnd_upper[r]) : longint'(bnd_lower[r]);
    if (l == r) return sl;
    num = t - longint'(bnd_time[l]);
    den = longint'(bnd_time[r]) - longint'(bnd_time[l]);
    if (den <= 0 || num < 0) return sl;
    ratio = (longint'(num) << 16) / den;
    if (ratio > 65536) ratio = 65536;
    ds = sr - sl;
    p = ds * longint'(ratio);
    return sl + (p >>> 16);
  endfunction

  // Sign of a*b - c*d, exact
  function automatic int cross_sign(longint a, longint b, longint c, longint d);
    logic signed [79:0] wa, wb, wc, wd, diff;
    wa = a; wb = b; wc = c; wd = d;
    diff = wa * wb - wc * wd;
    return (diff > 0) ? 1 : ((diff < 0) ? -1 : 0);
  endfunction

  // Work out the result of one accepted word and advance the table
  function automatic result_t predict_lookup(cmd_word_t w);
    result_t res;
    longint  qt, tmin, tmax, ru, rl, u, tl, tr, qd;
    int      l, r, su, sl;
    res = '{STS_OK, '0, '0, 1'b0};
    ru = 0;
    rl = 0;
    qt = w.query_time;
    if (w.cmd == CMD_LOAD) begin
      if (w.start_new) bnd_count = 0;
      if (w.pair_upper < w.pair_lower ||
          (bnd_count > 0 && w.pair_time <= bnd_time[bnd_count-1]))
        res.status = STS_REJECT;
      else if (bnd_count >= TBL_DEPTH)
        res.status = STS_FULL;
      else begin
        bnd_time[bnd_count]  = w.pair_time;
        bnd_lower[bnd_count] = w.pair_lower;
        bnd_upper[bnd_count] = w.pair_upper;
        bnd_count++;
      end
    end else if (bnd_count < 2) begin
      res.status = STS_FEW;
    end else begin
      tmin = bnd_time[0];
      tmax = bnd_time[bnd_count-1];
      case (w.cmd)
        CMD_RANGE: begin
          if (qt < tmin || qt > tmax) res.status = STS_OUTSIDE;
          else begin
            find_bracket(qt, l, r);
            ru = interp_bound(1'b1, l, r, qt);
            rl = interp_bound(1'b0, l, r, qt);
            if (ru > limit_reg) ru = limit_reg;
            if (rl < 0) rl = 0;
          end
        end
        CMD_UNBLK: begin
          ru = limit_reg;
          if (qt >= tmin - tol_reg && qt <= tmax + tol_reg) begin
            find_bracket(qt, l, r);
            if (kind_reg <= KIND_FOLLOW) ru = interp_bound(1'b0, l, r, qt);
            else if (kind_reg == KIND_OVERTAKE) begin
              u = interp_bound(1'b1, l, r, qt);
              rl = (u > 0) ? u : 0;
            end else res.status = STS_UNSUP;
          end
        end
        default: begin
          if (qt <= tmin || qt >= tmax) res.status = STS_OUTSIDE;
          else begin
            qd = w.query_dist;
            find_bracket(qt, l, r);
            tl = longint'(bnd_time[l]) - qt;
            tr = longint'(bnd_time[r]) - qt;
            su = cross_sign(tl, longint'(bnd_upper[r]) - qd, longint'(bnd_upper[l]) - qd, tr);
            sl = cross_sign(tl, longint'(bnd_lower[r]) - qd, longint'(bnd_lower[l]) - qd, tr);
            res.in_res = (su * sl < 0);
          end
        end
      endcase
    end
    res.range_upper = ru[31:0];
    res.range_lower = rl[31:0];
    return res;
  endfunction

  // Offer one word, hold it until taken, then log its expected result
  task automatic send_word(cmd_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {5'd0, w.query_dist, w.query_time, w.pair_upper, w.pair_lower,
                    w.pair_time, w.start_new, w.cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.insert(pending_results.size(), predict_lookup(w));
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic load_pair(bit fresh, longint t, longint lo, longint up);
    cmd_word_t w;
    w = '{CMD_LOAD, fresh, t[31:0], lo[31:0], up[31:0], $urandom, $urandom};
    send_word(w);
  endtask

  task automatic ask(cmd_e c, longint t, longint d);
    cmd_word_t w;
    w = '{c, $urandom_range(1), $urandom, $urandom, $urandom, t[31:0], d[31:0]};
    send_word(w);
  endtask

  // Wait for every result, let the block settle, then return on a falling edge
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, longint val);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val[CFG_DW-1:0];
    case (idx)
      CFG_KIND:  kind_reg = val[2:0];
      CFG_LIMIT: limit_reg = val & 64'h7FFF_FFFF;
      default:   tol_reg = val & 64'hFFFF;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Receiver readiness, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation: %h", m_axis_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[2:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[2:0]);
          err_count++;
        end
        if (m_axis_tdata[34:3] !== want.range_upper) begin
          $error("range_upper: expected %h, got %h", want.range_upper, m_axis_tdata[34:3]);
          err_count++;
        end
        if (m_axis_tdata[66:35] !== want.range_lower) begin
          $error("range_lower: expected %h, got %h", want.range_lower, m_axis_tdata[66:35]);
          err_count++;
        end
        if (m_axis_tdata[67] !== want.in_res) begin
          $error("inside_res: expected %0d, got %0d", want.in_res, m_axis_tdata[67]);
          err_count++;
        end
      end
    end
  end

  // Abort when no word moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Extremes of the fields, empty and short tables, rejects and spans
  task automatic test_directed();
    ask(CMD_RANGE, 0, 0);
    ask(CMD_UNBLK, 0, 0);
    ask(CMD_CONT, 0, 0);
    load_pair(1, 0, 10, 20);
    ask(CMD_RANGE, 0, 0);
    load_pair(0, 0, 30, 40);                               // time does not rise
    load_pair(0, 100, 50, 40);                             // upper below lower
    load_pair(1, -64'sh8000_0000, -64'sh8000_0000, 64'sh7FFF_FFFF);
    load_pair(0, 0, 64'sh0020_0000, 64'sh00A0_0000);
    load_pair(0, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
    ask(CMD_RANGE, -64'sh8000_0000, 0);
    ask(CMD_RANGE, 64'sh7FFF_FFFF, 0);
    ask(CMD_RANGE, 64'sh1234_5678, 0);
    ask(CMD_RANGE, -64'sh1234_5678, 0);
    ask(CMD_CONT, -64'sh8000_0000, 0);
    ask(CMD_CONT, 64'sh0001_0000, 64'sh0040_0000);
    ask(CMD_CONT, -64'sh0001_0000, -64'sh8000_0000);
    ask(CMD_UNBLK, 64'sh0100_0000, 0);                     // kind unknown
    load_pair(1, 64'sh0001_0000, -64'sh0010_0000, 64'sh0010_0000);
    load_pair(0, 64'sh0003_0000, -64'sh0010_0000, 64'sh0010_0000);
    ask(CMD_RANGE, 64'sh0002_0000, 0);
    ask(CMD_CONT, 64'sh0002_0000, 64'sh0010_0000);         // on the edge
    ask(CMD_CONT, 64'sh0002_0000, 0);
    ask(CMD_UNBLK, 64'sh0000_FFFF, 0);
    ask(CMD_UNBLK, 64'sh0003_0002, 0);
  endtask

  // Every kind, limit and tolerance extremes around the span edges
  task automatic test_config_extremes();
    longint lims[3] = '{0, 64'h7FFF_FFFF, 64'sh0008_0000};
    longint tols[3] = '{0, 65535, 1};
    for (int k = 0; k < 8; k++) begin
      write_reg(CFG_KIND, k);
      write_reg(CFG_LIMIT, lims[k % 3]);
      write_reg(CFG_TOL, tols[k % 3]);
      ask(CMD_UNBLK, 64'sh0001_0000 - tol_reg, 0);
      ask(CMD_UNBLK, 64'sh0001_0000 - tol_reg - 1, 0);
      ask(CMD_UNBLK, 64'sh0003_0000 + tol_reg, 0);
      ask(CMD_UNBLK, 64'sh0002_8000, 0);
      ask(CMD_RANGE, 64'sh0001_8000, 0);
    end
  endtask

  // Fill the table to its depth and push one more pair
  task automatic test_table_full();
    for (int i = 0; i <= TBL_DEPTH; i++)
      load_pair(i == 0, i * 64'sh0001_0000 - 64'sh0010_0000, i * 4096, i * 8192 + 65536);
    ask(CMD_RANGE, 64'sh0002_2000, 0);
    ask(CMD_CONT, 64'sh0020_4000, 64'sh0002_0000);
    ask(CMD_UNBLK, 64'sh0030_0000, 0);
  endtask

  // Random tables, mostly well-formed, queries around them, and noise
  task automatic test_random(int n_words);
    int sent, k;
    longint t, step, lo, up, tmin, tmax, dmin, dmax, qt;
    cmd_word_t w;
    sent = 0;
    while (sent < n_words) begin
      if ($urandom_range(99) < 85) begin
        k = ($urandom_range(19) == 0) ? $urandom_range(30, 66) : $urandom_range(2, 10);
        t = longint'($signed($urandom)) >>> $urandom_range(0, 8);
        tmin = t;
        dmin = 64'sh7FFF_FFFF;
        dmax = -64'sh8000_0000;
        for (int i = 0; i < k; i++) begin
          lo = longint'($signed($urandom)) >>> $urandom_range(0, 12);
          up = lo + ($urandom >> $urandom_range(1, 31));
          if (up > 64'sh7FFF_FFFF) up = 64'sh7FFF_FFFF;
          if ($urandom_range(29) == 0) up = lo - 1;          // broken pair
          if (lo < dmin) dmin = lo;
          if (up > dmax) dmax = up;
          load_pair(i == 0, t, lo, up);
          sent++;
          tmax = t;
          step = $urandom_range(1, 1 << $urandom_range(0, 24));
          if ($urandom_range(39) == 0) step = 0;             // time does not rise
          if (t + step > 64'sh7FFF_FFFF) break;
          t = t + step;
        end
        repeat ($urandom_range(3, 10)) begin
          qt = tmin - tol_reg - 2 + longint'($urandom_range(0, 32'hFFFF_FFFF)) %
               (tmax - tmin + 2 * tol_reg + 5);
          if (qt < -64'sh8000_0000) qt = -64'sh8000_0000;
          if (qt > 64'sh7FFF_FFFF) qt = 64'sh7FFF_FFFF;
          ask(cmd_e'($urandom_range(1, 3)), qt,
              dmin - 2 + longint'($urandom_range(0, 32'hFFFF_FFFF)) % (dmax - dmin + 5));
          sent++;
        end
      end else begin
        w = '{cmd_e'($urandom_range(3)), $urandom_range(1), $urandom, $urandom, $urandom,
              $urandom, $urandom};
        send_word(w);
        sent++;
      end
    end
  endtask

  // Receiver holds off while words keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    recv_stall_pct = 0;
    send_idle_pct = 0;
    load_pair(1, 0, 0, 65536);
    load_pair(0, 65536, 0, 131072);
    repeat (12) ask(cmd_e'($urandom_range(1, 3)), $urandom_range(0, 65536), 32768);
  endtask

  task automatic set_pace(int idle_pct, int stall_pct);
    drain();
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic reconfigure();
    write_reg(CFG_KIND, $urandom_range(7));
    write_reg(CFG_LIMIT, ($urandom_range(3) == 0) ? 64'h7FFF_FFFF : $urandom >> 1);
    write_reg(CFG_TOL, $urandom_range(65535));
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config_extremes();
    test_table_full();
    test_backpressure();
    set_pace(0, 0);
    reconfigure();
    test_random(130);
    set_pace(82, 0);
    reconfigure();
    test_random(130);
    set_pace(0, 82);
    reconfigure();
    test_random(130);
    set_pace(29, 29);
    reconfigure();
    test_random(130);
    drain();
    repeat (50) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      err_count++;
    end
    if (err_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: files.f
rtl/brl_pkg.sv
rtl/brl_ram.sv
rtl/brl_ctrl.sv
rtl/brl_dp.sv
rtl/st_boundary_range_lookup.sv
rtl/brl_chk.sv
tb/sv/testbench.sv
